// ===== rtl/core/mp2a_pkg.sv =====
`default_nettype none

package mp2a_pkg;

  localparam int MAX_WIDTH     = 1024;
  localparam int SAMPLE_BITS   = 16;
  localparam int HEIGHT_LIMIT  = 4096;
  localparam int STORE_DEPTH   = MAX_WIDTH / 2;
  localparam int SLOT_BITS     = $clog2(STORE_DEPTH);
  localparam int COL_BITS      = $clog2(MAX_WIDTH);
  localparam int ROW_BITS      = $clog2(HEIGHT_LIMIT);
  localparam int WIDTH_BITS    = 11;
  localparam int HEIGHT_BITS   = 13;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 16;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_PLANE_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PLANE_HEIGHT = 2'd1;

  localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 11'd28;
  localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 13'd28;

  localparam logic [1:0] POS_LOWER_LEFT  = 2'd2;
  localparam logic [1:0] POS_LOWER_RIGHT = 2'd3;

  typedef struct packed {
    logic                          right;
    logic signed [SAMPLE_BITS-1:0] value;
  } top_pair_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] value;
    logic [1:0]                    position;
    logic                          done;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/max_pool_2x2_argmax.sv =====
// 2x2 max pooling at stride 2 with argmax over a raster-order sample stream.
// Samples enter on the sample channel (valid/ready), one word per cycle, planes
// following one another with no gap. One result word leaves on the result
// channel for each 2x2 window: the window maximum, its position row*2+column
// (earliest position on ties) and a flag on the last window of a plane.
// A trailing odd row or column is consumed and ignored.
// Throughput is one sample per cycle while sample_ready is high. The maximum of
// each top pair is written to a 512-entry line store; the even-column sample of
// a bottom row reads it, and the registered read of that single-port store is
// covered by the odd-column sample that follows. A window's result is registered
// when its lower-right sample is accepted, into the skid register on a stall.
// When the receiver stalls, the output register holds its word and a second
// skid register takes one more; sample_ready is low while the skid register is
// full and rises in the cycle after the receiver takes the held word.
// Reset clears the counters, the holding registers and the output stage and
// sets both plane dimensions to 28. The line store is not cleared: no clearing
// pass runs; samples are accepted once reset ends. plane_width (index 0) and
// plane_height (index 1) are written through the always-ready configuration
// channel; the user must write them only while the block is idle (unenforced).
`default_nettype none

module max_pool_2x2_argmax (
  input  wire logic                                      clk,
  input  wire logic                                      rst,
  input  wire logic                                      sample_valid,
  output logic                                           sample_ready,
  input  wire logic signed [mp2a_pkg::SAMPLE_BITS-1:0]   sample_value,
  output logic                                           result_valid,
  input  wire logic                                      result_ready,
  output logic signed [mp2a_pkg::SAMPLE_BITS-1:0]        pooled_value,
  output logic [1:0]                                     winner_position,
  output logic                                           plane_done,
  input  wire logic                                      cfg_valid,
  output logic                                           cfg_ready,
  input  wire logic [mp2a_pkg::CFG_INDEX_BITS-1:0]       cfg_index,
  input  wire logic [mp2a_pkg::CFG_DATA_BITS-1:0]        cfg_data
);

  logic [mp2a_pkg::WIDTH_BITS-1:0]  plane_width;
  logic [mp2a_pkg::HEIGHT_BITS-1:0] plane_height;
  logic [mp2a_pkg::COL_BITS-1:0]    column_count;
  logic [mp2a_pkg::ROW_BITS-1:0]    row_count;
  logic signed [mp2a_pkg::SAMPLE_BITS-1:0] upper_left_hold;
  logic signed [mp2a_pkg::SAMPLE_BITS-1:0] lower_left_hold;

  mp2a_pkg::top_pair_t top_pair_store [mp2a_pkg::STORE_DEPTH];
  mp2a_pkg::top_pair_t store_rd_data;
  mp2a_pkg::top_pair_t store_wr_data;
  logic                store_wr_en;
  logic                store_rd_en;
  logic [mp2a_pkg::SLOT_BITS-1:0] slot;

  mp2a_pkg::result_t out_word;
  mp2a_pkg::result_t skid_word;
  mp2a_pkg::result_t new_word;
  logic              skid_valid;

  logic [mp2a_pkg::WIDTH_BITS-1:0]  width_used;
  logic [mp2a_pkg::HEIGHT_BITS-1:0] height_used;
  logic [mp2a_pkg::WIDTH_BITS-1:0]  width_even;
  logic [mp2a_pkg::HEIGHT_BITS-1:0] height_even;
  logic [mp2a_pkg::COL_BITS-1:0]    column_last;
  logic [mp2a_pkg::ROW_BITS-1:0]    row_last;
  logic accept;
  logic in_window;
  logic produce;
  logic out_free;
  logic signed [mp2a_pkg::SAMPLE_BITS-1:0] best_mid;
  logic [1:0]                              pos_mid;

  assign cfg_ready    = 1'b1;
  assign sample_ready = !skid_valid;
  assign accept       = sample_valid && sample_ready;

  always_comb begin
    if (plane_width < 11'd2) begin
      width_used = 11'd2;
    end else if (plane_width > 11'(mp2a_pkg::MAX_WIDTH)) begin
      width_used = 11'(mp2a_pkg::MAX_WIDTH);
    end else begin
      width_used = plane_width;
    end
    if (plane_height < 13'd2) begin
      height_used = 13'd2;
    end else if (plane_height > 13'(mp2a_pkg::HEIGHT_LIMIT)) begin
      height_used = 13'(mp2a_pkg::HEIGHT_LIMIT);
    end else begin
      height_used = plane_height;
    end
  end

  assign width_even  = {width_used[mp2a_pkg::WIDTH_BITS-1:1], 1'b0};
  assign height_even = {height_used[mp2a_pkg::HEIGHT_BITS-1:1], 1'b0};
  assign column_last = mp2a_pkg::COL_BITS'(width_used - 11'd1);
  assign row_last    = mp2a_pkg::ROW_BITS'(height_used - 13'd1);
  assign in_window   = ({1'b0, column_count} < width_even) && ({1'b0, row_count} < height_even);
  assign slot        = column_count[mp2a_pkg::COL_BITS-1:1];

  // The read for a bottom pair is issued on its left sample, so it is ready
  // for the right one whenever that arrives.
  assign store_rd_en = accept && !column_count[0];
  assign store_wr_en = accept && in_window && !row_count[0] && column_count[0];
  assign produce     = accept && in_window && row_count[0] && column_count[0];

  always_comb begin
    if (sample_value > upper_left_hold) begin
      store_wr_data.value = sample_value;
      store_wr_data.right = 1'b1;
    end else begin
      store_wr_data.value = upper_left_hold;
      store_wr_data.right = 1'b0;
    end
  end

  always_comb begin
    best_mid = $signed(store_rd_data.value);
    pos_mid  = {1'b0, store_rd_data.right};
    if (lower_left_hold > best_mid) begin
      best_mid = lower_left_hold;
      pos_mid  = mp2a_pkg::POS_LOWER_LEFT;
    end
    new_word.value    = best_mid;
    new_word.position = pos_mid;
    if (sample_value > best_mid) begin
      new_word.value    = sample_value;
      new_word.position = mp2a_pkg::POS_LOWER_RIGHT;
    end
    new_word.done = ({1'b0, column_count} == width_even - 11'd1) &&
                    ({1'b0, row_count} == height_even - 13'd1);
  end

  always_ff @(posedge clk) begin
    if (store_wr_en) begin
      top_pair_store[slot] <= store_wr_data;
    end
    if (store_rd_en) begin
      store_rd_data <= top_pair_store[slot];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      plane_width  <= mp2a_pkg::WIDTH_RESET;
      plane_height <= mp2a_pkg::HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == mp2a_pkg::CFG_PLANE_WIDTH) begin
        plane_width <= cfg_data[mp2a_pkg::WIDTH_BITS-1:0];
      end else if (cfg_index == mp2a_pkg::CFG_PLANE_HEIGHT) begin
        plane_height <= cfg_data[mp2a_pkg::HEIGHT_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count    <= '0;
      row_count       <= '0;
      upper_left_hold <= '0;
      lower_left_hold <= '0;
    end else if (accept) begin
      if (in_window && !column_count[0]) begin
        if (row_count[0]) begin
          lower_left_hold <= sample_value;
        end else begin
          upper_left_hold <= sample_value;
        end
      end
      if (column_count >= column_last) begin
        column_count <= '0;
        if (row_count >= row_last) begin
          row_count <= '0;
        end else begin
          row_count <= row_count + 1'b1;
        end
      end else begin
        column_count <= column_count + 1'b1;
      end
    end
  end

  assign out_free = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else begin
      if (out_free) begin
        if (skid_valid) begin
          result_valid <= 1'b1;
          skid_valid   <= 1'b0;
        end else begin
          result_valid <= produce;
        end
      end else if (produce) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_word <= skid_valid ? skid_word : new_word;
    end else if (produce) begin
      skid_word <= new_word;
    end
  end

  assign pooled_value    = out_word.value;
  assign winner_position = out_word.position;
  assign plane_done      = out_word.done;

  a_skid_behind_output: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> result_valid)
    else $error("skid register full while output register empty");

  a_skid_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(result_valid && !result_ready))
    else $error("skid register filled without a stalled output");

  a_left_then_right: assert property (@(posedge clk) disable iff (rst)
    (accept && !column_count[0]) |=>
      (column_count == $past(column_count) + 1'b1) || (column_count == '0))
    else $error("column counter skipped after a left sample");

  a_drain_from_skid: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && result_ready) |=> result_valid && !skid_valid)
    else $error("skid word not moved to the output register");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`default_nettype none

module tb;

  localparam logic [1:0] POS_UPPER_LEFT  = 2'd0;
  localparam logic [1:0] POS_UPPER_RIGHT = 2'd1;
  localparam logic [mp2a_pkg::CFG_INDEX_BITS-1:0] CFG_SPARE_LOW  = 2'd2;
  localparam logic [mp2a_pkg::CFG_INDEX_BITS-1:0] CFG_SPARE_HIGH = 2'd3;

  localparam int RANDOM_ITEMS  = 800;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 400;
  localparam int STALL_LIMIT   = 2000;

  typedef struct packed {
    logic signed [mp2a_pkg::SAMPLE_BITS-1:0] sample;
    logic                                    has_result;
    mp2a_pkg::result_t                       result;
  } directed_row_t;

  localparam mp2a_pkg::result_t NO_WORD = '0;

  // Six 2x2 planes: windows of extreme samples carry their result word, the
  // others are checked against the predictor.
  localparam directed_row_t DIRECTED [24] = '{
    '{16'sh8000, 1'b0, NO_WORD},
    '{16'sh8000, 1'b0, NO_WORD},
    '{16'sh8000, 1'b0, NO_WORD},
    '{16'sh8000, 1'b1, '{16'sh8000, POS_UPPER_LEFT, 1'b1}},
    '{16'sh7FFF, 1'b0, NO_WORD},
    '{16'sh7FFF, 1'b0, NO_WORD},
    '{16'sh7FFF, 1'b0, NO_WORD},
    '{16'sh7FFF, 1'b1, '{16'sh7FFF, POS_UPPER_LEFT, 1'b1}},
    '{16'sh0000, 1'b0, NO_WORD},
    '{16'sh0005, 1'b0, NO_WORD},
    '{16'shFFFD, 1'b0, NO_WORD},
    '{16'sh0005, 1'b0, NO_WORD},
    '{16'sh8000, 1'b0, NO_WORD},
    '{16'sh8000, 1'b0, NO_WORD},
    '{16'sh7FFF, 1'b0, NO_WORD},
    '{16'sh7FFF, 1'b1, '{16'sh7FFF, mp2a_pkg::POS_LOWER_LEFT, 1'b1}},
    '{16'shFFFB, 1'b0, NO_WORD},
    '{16'shFFFC, 1'b0, NO_WORD},
    '{16'shFFFD, 1'b0, NO_WORD},
    '{16'shFFFE, 1'b0, NO_WORD},
    '{16'sh7FFF, 1'b0, NO_WORD},
    '{16'sh8000, 1'b0, NO_WORD},
    '{16'shFFFF, 1'b0, NO_WORD},
    '{16'sh0000, 1'b1, '{16'sh7FFF, POS_UPPER_LEFT, 1'b1}}
  };

  logic                                    clk = 1'b0;
  logic                                    rst = 1'b1;
  logic                                    sample_valid;
  logic                                    sample_ready;
  logic signed [mp2a_pkg::SAMPLE_BITS-1:0] sample_value;
  logic                                    result_valid;
  logic                                    result_ready;
  logic signed [mp2a_pkg::SAMPLE_BITS-1:0] pooled_value;
  logic [1:0]                              winner_position;
  logic                                    plane_done;
  logic                                    cfg_valid;
  logic                                    cfg_ready;
  logic [mp2a_pkg::CFG_INDEX_BITS-1:0]     cfg_index;
  logic [mp2a_pkg::CFG_DATA_BITS-1:0]      cfg_data;

  mp2a_pkg::top_pair_t                     pair_line [mp2a_pkg::STORE_DEPTH];
  logic signed [mp2a_pkg::SAMPLE_BITS-1:0] upper_left;
  logic signed [mp2a_pkg::SAMPLE_BITS-1:0] lower_left;
  int unsigned                             col_pos;
  int unsigned                             row_pos;
  logic [mp2a_pkg::WIDTH_BITS-1:0]         width_reg;
  logic [mp2a_pkg::HEIGHT_BITS-1:0]        height_reg;

  mp2a_pkg::result_t pending_windows [$];
  int      errors = 0;
  int      windows_seen = 0;
  int      idle_cycles = 0;

  max_pool_2x2_argmax uut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic pool_predict(input logic signed [mp2a_pkg::SAMPLE_BITS-1:0] s,
                              output bit got, output mp2a_pkg::result_t word);
    int unsigned w;
    int unsigned h;
    int unsigned used_w;
    int unsigned used_h;
    int unsigned slot;
    logic signed [mp2a_pkg::SAMPLE_BITS-1:0] best;
    logic signed [mp2a_pkg::SAMPLE_BITS-1:0] kept;
    logic [1:0] pos;
    got = 1'b0;
    word = NO_WORD;
    w = 32'(width_reg);
    if (w < 2) w = 2;
    else if (w > mp2a_pkg::MAX_WIDTH) w = mp2a_pkg::MAX_WIDTH;
    h = 32'(height_reg);
    if (h < 2) h = 2;
    else if (h > mp2a_pkg::HEIGHT_LIMIT) h = mp2a_pkg::HEIGHT_LIMIT;
    used_w = w & ~32'd1;
    used_h = h & ~32'd1;
    if (col_pos < used_w && row_pos < used_h) begin
      slot = (col_pos >> 1) % mp2a_pkg::STORE_DEPTH;
      if (row_pos % 2 == 0) begin
        if (col_pos % 2 == 0) begin
          upper_left = s;
        end else if (s > upper_left) begin
          pair_line[slot] = '{1'b1, s};
        end else begin
          pair_line[slot] = '{1'b0, upper_left};
        end
      end else begin
        if (col_pos % 2 == 0) begin
          lower_left = s;
        end else begin
          kept = pair_line[slot].value;
          best = kept;
          pos = pair_line[slot].right ? POS_UPPER_RIGHT : POS_UPPER_LEFT;
          if (lower_left > best) begin
            best = lower_left;
            pos = mp2a_pkg::POS_LOWER_LEFT;
          end
          if (s > best) begin
            best = s;
            pos = mp2a_pkg::POS_LOWER_RIGHT;
          end
          word.value = best;
          word.position = pos;
          word.done = (col_pos == used_w - 1 && row_pos == used_h - 1);
          got = 1'b1;
        end
      end
    end
    if (col_pos >= w - 1) begin
      col_pos = 0;
      row_pos = (row_pos >= h - 1) ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
  endtask

  task automatic write_register(input logic [mp2a_pkg::CFG_INDEX_BITS-1:0] index,
                                input logic [mp2a_pkg::CFG_DATA_BITS-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (index)
      mp2a_pkg::CFG_PLANE_WIDTH: begin
        width_reg = data[mp2a_pkg::WIDTH_BITS-1:0];
      end
      mp2a_pkg::CFG_PLANE_HEIGHT: begin
        height_reg = data[mp2a_pkg::HEIGHT_BITS-1:0];
      end
      default: begin
      end
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic offer_sample(input logic signed [mp2a_pkg::SAMPLE_BITS-1:0] s,
                              input int gap);
    repeat (gap) begin
      @(negedge clk);
      sample_valid <= 1'b0;
    end
    @(negedge clk);
    sample_valid <= 1'b1;
    sample_value <= s;
    do @(posedge clk); while (!sample_ready);
  endtask

  function automatic logic signed [mp2a_pkg::SAMPLE_BITS-1:0] draw_sample();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 3))
          0: return 16'sh8000;
          1: return 16'sh7FFF;
          2: return 16'shFFFF;
          default: return 16'sh0000;
        endcase
      end
      // A narrow range makes ties within a window frequent.
      1: return 16'($urandom_range(0, 6) - 3);
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic feed_random(input bit quiet);
    logic signed [mp2a_pkg::SAMPLE_BITS-1:0] s;
    bit got;
    mp2a_pkg::result_t word;
    s = draw_sample();
    offer_sample(s, quiet ? 0 : $urandom_range(0, 8));
    pool_predict(s, got, word);
    if (got) pending_windows.push_back(word);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    sample_valid <= 1'b0;
    while (pending_windows.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int sent;
    int span;
    bit quiet;
    bit got;
    mp2a_pkg::result_t word;
    logic [mp2a_pkg::CFG_DATA_BITS-1:0] data;
    sample_valid = 1'b0;
    sample_value = '0;
    cfg_valid = 1'b0;
    cfg_index = mp2a_pkg::CFG_PLANE_WIDTH;
    cfg_data = '0;
    for (int i = 0; i < mp2a_pkg::STORE_DEPTH; i++) pair_line[i] = '0;
    upper_left = '0;
    lower_left = '0;
    col_pos = 0;
    row_pos = 0;
    width_reg = mp2a_pkg::WIDTH_RESET;
    height_reg = mp2a_pkg::HEIGHT_RESET;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_register(mp2a_pkg::CFG_PLANE_WIDTH, 16'd2);
    write_register(mp2a_pkg::CFG_PLANE_HEIGHT, 16'd2);
    foreach (DIRECTED[i]) begin
      offer_sample(DIRECTED[i].sample, $urandom_range(0, 8));
      pool_predict(DIRECTED[i].sample, got, word);
      if (DIRECTED[i].has_result) begin
        pending_windows.push_back(DIRECTED[i].result);
      end else if (got) begin
        pending_windows.push_back(word);
      end
    end
    wait_idle();

    // One full top row at the widest size writes every line store entry, so that
    // later size changes in the middle of a plane only ever read written entries.
    write_register(mp2a_pkg::CFG_PLANE_WIDTH, 16'hFFFF);
    write_register(mp2a_pkg::CFG_PLANE_HEIGHT, 16'hFFFF);
    write_register(CFG_SPARE_HIGH, 16'hFFFF);
    repeat (mp2a_pkg::MAX_WIDTH) feed_random(1'b0);
    wait_idle();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      span = $urandom_range(0, 3);
      if (span != 1) begin
        data = 16'($urandom());
        case ($urandom_range(0, 9))
          0: data[mp2a_pkg::WIDTH_BITS-1:0] = 11'($urandom_range(0, 1));
          1: data[mp2a_pkg::WIDTH_BITS-1:0] = 11'($urandom_range(mp2a_pkg::MAX_WIDTH, 2047));
          default: data[mp2a_pkg::WIDTH_BITS-1:0] = 11'($urandom_range(2, 13));
        endcase
        write_register(mp2a_pkg::CFG_PLANE_WIDTH, data);
      end
      if (span != 0) begin
        data = 16'($urandom());
        case ($urandom_range(0, 9))
          0: data[mp2a_pkg::HEIGHT_BITS-1:0] = 13'($urandom_range(0, 1));
          1: data[mp2a_pkg::HEIGHT_BITS-1:0] =
               13'($urandom_range(mp2a_pkg::HEIGHT_LIMIT, 8191));
          default: data[mp2a_pkg::HEIGHT_BITS-1:0] = 13'($urandom_range(2, 9));
        endcase
        write_register(mp2a_pkg::CFG_PLANE_HEIGHT, data);
      end
      if ($urandom_range(0, 5) == 0) begin
        write_register($urandom_range(0, 1) ? CFG_SPARE_LOW : CFG_SPARE_HIGH, 16'($urandom()));
      end
      quiet = ($urandom_range(0, 3) == 0);
      span = $urandom_range(20, 160);
      repeat (span) feed_random(quiet);
      sent += span;
      wait_idle();
    end

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    int gap;
    bit calm;
    bit held;
    mp2a_pkg::result_t want;
    result_ready = 1'b0;
    calm = 1'b0;
    held = 1'b0;
    while (rst) @(negedge clk);
    forever begin
      // A long hold-off fills the output stage and pushes back on the sample side.
      if (!held && windows_seen >= 100) begin
        held = 1'b1;
        repeat (HOLD_CYCLES) begin
          @(negedge clk);
          result_ready <= 1'b0;
        end
      end
      if (windows_seen % 32 == 0) calm = ($urandom_range(0, 2) == 0);
      gap = calm ? 0 : $urandom_range(0, 8);
      repeat (gap) begin
        @(negedge clk);
        result_ready <= 1'b0;
      end
      @(negedge clk);
      result_ready <= 1'b1;
      do @(posedge clk); while (!result_valid);
      if (pending_windows.size() == 0) begin
        errors++;
        $display("%0t: unexpected word value %0d position %0d done %0b",
                 $time, pooled_value, winner_position, plane_done);
      end else begin
        want = pending_windows.pop_front();
        if (pooled_value !== want.value) begin
          errors++;
          $display("%0t: pooled_value expected %0d actual %0d",
                   $time, want.value, pooled_value);
        end
        if (winner_position !== want.position) begin
          errors++;
          $display("%0t: winner_position expected %0d actual %0d",
                   $time, want.position, winner_position);
        end
        if (plane_done !== want.done) begin
          errors++;
          $display("%0t: plane_done expected %0b actual %0b",
                   $time, want.done, plane_done);
        end
      end
      windows_seen++;
    end
  end

  always @(posedge clk) begin
    if (rst || (sample_valid && sample_ready) || (result_valid && result_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

endmodule

`default_nettype wire
